/* src/hbsf_pkg.sv */
// ----------------------------------------------------------------------------
// hbsf_pkg
// Shared constants and controller/datapath interface types for the HDLC
// byte-stuffing framer.
// ----------------------------------------------------------------------------
package hbsf_pkg;

  // Default payload size; the frame store holds twice this many bytes
  localparam int PACKET_BYTES_DEF = 64;

  // Framing and escape codes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  // Result word geometry
  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = 64;
  localparam int CNT_W      = 4;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;        // accept input item, stuff first byte
    logic write_esc2;  // write second byte of an escape pair
    logic write_flag;  // write closing flag
    logic read;        // issue one store read for the drain
    logic load_drop;   // load the dropped-frame result
    logic clear_word;  // start a new result word
    logic end_frame;   // close frame, clear fill and overflow
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic esc;         // incoming byte needs escaping (frame not overflowed)
    logic ovf_next;    // frame overflowed after this byte
    logic last_in;     // incoming item carries the last-byte mark
    logic last_held;   // held last-byte mark of the escaped item
    logic ovf;         // overflow mark
    logic word_end;    // current read finishes the result word
    logic final_word;  // result word on the output is the last of the frame
  } sts_t;

endpackage

/* src/hbsf_ram.sv */
// ----------------------------------------------------------------------------
// hbsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/hbsf_datapath.sv */
// ----------------------------------------------------------------------------
// hbsf_datapath
// Byte stuffing into the frame store, fill and overflow tracking, and
// assembly of result words during the drain.
// ----------------------------------------------------------------------------
module hbsf_datapath #(
  parameter int PACKET_BYTES = hbsf_pkg::PACKET_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hbsf_pkg::cmd_t                      cmd,
  output hbsf_pkg::sts_t                      sts,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  output logic [hbsf_pkg::WORD_W-1:0]         frame_word,
  output logic [hbsf_pkg::CNT_W-1:0]          bytes_valid,
  output logic                                last_word,
  output logic                                frame_dropped
);

  localparam int DEPTH = 2 * PACKET_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] LIMIT = FW'(DEPTH - 2);

  logic [FW-1:0]               fill;
  logic                        ovf;
  logic [7:0]                  esc2_byte;
  logic                        last_held;
  logic [FW-1:0]               rd_pos;
  logic [2:0]                  lane_iss;
  logic                        rd_pend;
  logic [2:0]                  rd_lane;
  logic                        rd_zero;
  logic [hbsf_pkg::WORD_W-1:0] acc;
  logic [hbsf_pkg::CNT_W-1:0]  bcount;
  logic                        last_q;
  logic                        drop_q;

  logic [FW-1:0] eff;
  logic [FW-1:0] fill_new;
  logic [FW-1:0] fill_m1;
  logic          byte_esc;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;

  // Position 0 is never written; the opening flag is supplied on the drain
  assign byte_esc = (data_byte == hbsf_pkg::FLAG_BYTE) || (data_byte == hbsf_pkg::ESC_BYTE);
  assign eff      = (fill == '0) ? FW'(1) : fill;
  assign fill_new = eff + (byte_esc ? FW'(2) : FW'(1));
  assign fill_m1  = fill - FW'(1);

  // Status to the controller
  always_comb begin
    sts.esc        = !ovf && byte_esc;
    sts.ovf_next   = ovf || (fill_new > LIMIT);
    sts.last_in    = last_byte;
    sts.last_held  = last_held;
    sts.ovf        = ovf;
    sts.word_end   = (lane_iss == 3'd7) || (rd_pos == fill);
    sts.final_word = last_q;
  end

  // Select the store write
  always_comb begin
    we    = 1'b0;
    waddr = fill[AW-1:0];
    wdata = data_byte;
    if (cmd.take && !ovf) begin
      we    = 1'b1;
      waddr = eff[AW-1:0];
      wdata = byte_esc ? hbsf_pkg::ESC_BYTE : data_byte;
    end else if (cmd.write_esc2) begin
      we    = 1'b1;
      waddr = fill_m1[AW-1:0];
      wdata = esc2_byte;
    end else if (cmd.write_flag) begin
      we    = 1'b1;
      waddr = fill[AW-1:0];
      wdata = hbsf_pkg::FLAG_BYTE;
    end
  end

  hbsf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_pos[AW-1:0]),
    .rdata(rdata)
  );

  // Track fill count and overflow mark
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      ovf       <= 1'b0;
      last_held <= 1'b0;
    end else begin
      if (cmd.take) begin
        last_held <= last_byte;
        if (!ovf) begin
          fill <= fill_new;
          ovf  <= fill_new > LIMIT;
        end
      end else if (cmd.end_frame) begin
        fill <= '0;
        ovf  <= 1'b0;
      end
    end
  end

  // Hold second byte of an escape pair
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      esc2_byte <= (data_byte == hbsf_pkg::FLAG_BYTE) ? hbsf_pkg::ESC_FLAG
                                                      : hbsf_pkg::ESC_ESC;
    end
  end

  // Advance drain read position and pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pos   <= '0;
      lane_iss <= '0;
      rd_pend  <= 1'b0;
      rd_lane  <= '0;
      rd_zero  <= 1'b0;
    end else begin
      rd_pend <= cmd.read;
      if (cmd.read) begin
        rd_pos   <= rd_pos + FW'(1);
        lane_iss <= lane_iss + 3'd1;
        rd_lane  <= lane_iss;
        rd_zero  <= (rd_pos == '0);
      end else if (cmd.clear_word) begin
        lane_iss <= '0;
      end
      if (cmd.end_frame) begin
        rd_pos <= '0;
      end
    end
  end

  // Assemble result word, earliest byte in the top lane
  always_ff @(posedge clk) begin
    if (cmd.clear_word || cmd.load_drop) begin
      acc <= '0;
    end else if (rd_pend) begin
      acc[{~rd_lane, 3'b000} +: 8] <= rd_zero ? hbsf_pkg::FLAG_BYTE : rdata;
    end
  end

  // Result count and marks
  always_ff @(posedge clk) begin
    if (rst) begin
      bcount <= '0;
      last_q <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      if (cmd.load_drop) begin
        bcount <= '0;
        last_q <= 1'b1;
        drop_q <= 1'b1;
      end else if (cmd.clear_word) begin
        bcount <= '0;
        last_q <= 1'b0;
        drop_q <= 1'b0;
      end else begin
        if (rd_pend) begin
          bcount <= bcount + 4'd1;
        end
        if (cmd.read && (rd_pos == fill)) begin
          last_q <= 1'b1;
        end
      end
    end
  end

  assign frame_word    = acc;
  assign bytes_valid   = bcount;
  assign last_word     = last_q;
  assign frame_dropped = drop_q;

  // Drain never reads past the closing flag
  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> (rd_pos <= fill))
    else $error("drain read beyond closing flag");

  // A word never collects more than eight bytes
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (bcount < 4'd8))
    else $error("result word overfilled");

endmodule

/* src/hbsf_ctrl.sv */
// ----------------------------------------------------------------------------
// hbsf_ctrl
// Controller state machine: sequences stuffing writes, closing flag, store
// drain and result handshake.
// ----------------------------------------------------------------------------
module hbsf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output hbsf_pkg::cmd_t cmd,
  input  hbsf_pkg::sts_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ESC2  = 6'b000010,
    ST_CLOSE = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.esc) begin
            state_next = ST_ESC2;
          end else if (sts.last_in) begin
            if (sts.ovf_next) begin
              cmd.load_drop = 1'b1;
              state_next    = ST_EMIT;
            end else begin
              state_next = ST_CLOSE;
            end
          end
        end
      end
      ST_ESC2: begin
        cmd.write_esc2 = 1'b1;
        if (sts.last_held) begin
          if (sts.ovf) begin
            cmd.load_drop = 1'b1;
            state_next    = ST_EMIT;
          end else begin
            state_next = ST_CLOSE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        cmd.write_flag = 1'b1;
        cmd.clear_word = 1'b1;
        state_next     = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.read = 1'b1;
        if (sts.word_end) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (sts.final_word) begin
            cmd.end_frame = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            cmd.clear_word = 1'b1;
            state_next     = ST_DRAIN;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Input and output sides are never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open in the same cycle");

  // An accepted last byte leaves the input side closed in the next cycle
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && sts.last_in) |=> !in_ready)
    else $error("input taken right after last byte");

  // A non-final word hands back to the drain
  a_resume_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !sts.final_word) |=> (state == ST_DRAIN))
    else $error("drain not resumed after word");

endmodule

/* src/hdlc_byte_stuffing_framer.sv */
// ----------------------------------------------------------------------------
// hdlc_byte_stuffing_framer
// HDLC-style byte-stuffing framer: stuffs payload bytes into a frame store
// and emits the flagged frame as 64-bit words.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_ready   data_byte, last_byte
//   output   out        out_valid / out_ready frame_word, bytes_valid,
//                                             last_word, frame_dropped
//
// An escaped byte needs two store writes on the single write port, so the
// input side stays closed while the second is written. A last byte is
// followed by the closing flag write, then each result word is read one
// byte a cycle from the byte-wide store with registered read data and
// shown until the output takes it. A dropped frame shows its result the
// cycle after its last byte, or after the escape write when that byte needs one.
// Synchronous reset clears the control state; the store needs no clearing.
// ----------------------------------------------------------------------------
module hdlc_byte_stuffing_framer #(
  parameter int PACKET_BYTES = hbsf_pkg::PACKET_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hbsf_pkg::WORD_W-1:0] frame_word,
  output logic [hbsf_pkg::CNT_W-1:0]  bytes_valid,
  output logic                        last_word,
  output logic                        frame_dropped
);

  hbsf_pkg::cmd_t cmd;
  hbsf_pkg::sts_t sts;

  hbsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  hbsf_datapath #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .frame_word   (frame_word),
    .bytes_valid  (bytes_valid),
    .last_word    (last_word),
    .frame_dropped(frame_dropped)
  );

endmodule
